### rtl/stac_pkg.sv
`timescale 1ns / 1ps
package stac_pkg;

    // coordinate and intermediate widths
    localparam int COORD_BITS      = 16;
    localparam int ANGLE_FRAC_DEF  = 12;
    localparam int ANGLE_W         = 15;
    localparam int LIMIT_W         = 40;
    localparam int DIFF_W          = COORD_BITS + 1;
    localparam int PROD_W          = 2 * DIFF_W;
    localparam int CROSS_W         = PROD_W + 1;
    localparam int DOT_W           = PROD_W + 2;
    localparam int MAG_W           = DOT_W;
    localparam int NPROD_W         = COORD_BITS + CROSS_W;
    localparam int NSUM_W          = NPROD_W + 2;
    localparam int SMALL_BITS      = 20;
    localparam int SQS_W           = 2 * SMALL_BITS + 2;
    localparam int SCALE_BITS      = 30;
    localparam int SHIFT_MAX       = MAG_W - SCALE_BITS;
    localparam int SHIFT_W         = $clog2(SHIFT_MAX + 1);
    localparam int SQ_W            = 2 * SCALE_BITS;
    localparam int RAD_W           = SQ_W + 2;
    localparam int ROOT_W          = RAD_W / 2;
    localparam int REM_W           = ROOT_W + 3;

    // CORDIC datapath
    localparam int  INT_FRAC       = 30;
    localparam int  CORDIC_STEPS   = 30;
    localparam int  CW             = 35;
    localparam int  ZW             = 35;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // APB register map
    localparam int APB_DATA_W      = 64;
    localparam int PADDR_W         = 4;
    localparam logic [0:0] REG_DEGEN_LIMIT = 1'b0;

    typedef struct packed {
        logic                  coll;
        logic                  nneg;
        logic                  dneg;
        logic [SCALE_BITS-1:0] x_mag;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:       v = ZW'(64'sd843314857);
            1:       v = ZW'(64'sd497837829);
            2:       v = ZW'(64'sd263043837);
            3:       v = ZW'(64'sd133525159);
            4:       v = ZW'(64'sd67021687);
            5:       v = ZW'(64'sd33543516);
            6:       v = ZW'(64'sd16775851);
            7:       v = ZW'(64'sd8388437);
            8:       v = ZW'(64'sd4194283);
            9:       v = ZW'(64'sd2097149);
            default: v = ZW'(64'sd1 <<< (INT_FRAC - i));
        endcase
        return v;
    endfunction

endpackage

### rtl/stac_if.sv
`timescale 1ns / 1ps
interface stac_in_if;
    import stac_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  start_x;
    logic signed [COORD_BITS-1:0]  start_y;
    logic signed [COORD_BITS-1:0]  start_z;
    logic signed [COORD_BITS-1:0]  mid_x;
    logic signed [COORD_BITS-1:0]  mid_y;
    logic signed [COORD_BITS-1:0]  mid_z;
    logic signed [COORD_BITS-1:0]  end_x;
    logic signed [COORD_BITS-1:0]  end_y;
    logic signed [COORD_BITS-1:0]  end_z;
    logic signed [COORD_BITS-1:0]  normal_x;
    logic signed [COORD_BITS-1:0]  normal_y;
    logic signed [COORD_BITS-1:0]  normal_z;

    modport source (output valid, start_x, start_y, start_z, mid_x, mid_y, mid_z,
                    end_x, end_y, end_z, normal_x, normal_y, normal_z, input ready);
    modport sink   (input valid, start_x, start_y, start_z, mid_x, mid_y, mid_z,
                    end_x, end_y, end_z, normal_x, normal_y, normal_z, output ready);
endinterface

interface stac_out_if;
    import stac_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [ANGLE_W-1:0]  turn_angle;
    logic                       status;

    modport source (output valid, turn_angle, status, input ready);
    modport sink   (input valid, turn_angle, status, output ready);
endinterface

### rtl/signed_turn_angle_core.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// i_in      in   valid/ready    start_*, mid_*, end_*, normal_* (Q8.8 each)
// o_out     out  valid/ready    turn_angle (Q3.12), status
// apb       in   psel/penable   degenerate_limit at byte address 0
//
// One transaction per cycle sustained while the output is taken; 8 geometry
// stages, 31 square-root stages (one root bit each), 32 CORDIC stages.
// Synchronous active-low reset clears all valid bits and sets the limit to 1.
// The whole pipeline advances together; it holds only while the output
// register is full and not taken, so i_in.ready drops in that cycle only.
module signed_turn_angle_core #(
    parameter int ANGLE_FRAC_BITS = stac_pkg::ANGLE_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    stac_in_if.sink                           i_in,
    stac_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [stac_pkg::PADDR_W-1:0]      paddr,
    input  logic [stac_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [stac_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import stac_pkg::*;

    logic                         en;
    logic [LIMIT_W-1:0]           limit;
    logic signed [COORD_BITS-1:0] pt_a [3];
    logic signed [COORD_BITS-1:0] pt_b [3];
    logic signed [COORD_BITS-1:0] pt_c [3];
    logic signed [COORD_BITS-1:0] pt_n [3];
    logic                         fr_valid;
    logic [RAD_W-1:0]             fr_rad;
    t_side                        fr_side;
    logic                         sq_valid;
    logic [ROOT_W-1:0]            sq_root;
    t_side                        sq_side;
    logic                         co_valid;

    assign pt_a[0] = i_in.start_x;
    assign pt_a[1] = i_in.start_y;
    assign pt_a[2] = i_in.start_z;
    assign pt_b[0] = i_in.mid_x;
    assign pt_b[1] = i_in.mid_y;
    assign pt_b[2] = i_in.mid_z;
    assign pt_c[0] = i_in.end_x;
    assign pt_c[1] = i_in.end_y;
    assign pt_c[2] = i_in.end_z;
    assign pt_n[0] = i_in.normal_x;
    assign pt_n[1] = i_in.normal_y;
    assign pt_n[2] = i_in.normal_z;

    assign en          = !co_valid || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = co_valid;

    stac_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (limit)
    );

    stac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_a     (pt_a),
        .i_b     (pt_b),
        .i_c     (pt_c),
        .i_n     (pt_n),
        .i_limit (limit),
        .o_valid (fr_valid),
        .o_rad   (fr_rad),
        .o_side  (fr_side)
    );

    stac_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_rad   (fr_rad),
        .i_side  (fr_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    stac_cordic #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (sq_valid),
        .i_root   (sq_root),
        .i_side   (sq_side),
        .o_valid  (co_valid),
        .o_angle  (o_out.turn_angle),
        .o_status (o_out.status)
    );

`ifndef NO_ASSERTIONS
    a_ready_only_on_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> o_out.valid && !o_out.ready)
        else $error("input stalled while output side is free");
`endif

endmodule

### rtl/stac_regs.sv
`timescale 1ns / 1ps
module stac_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [stac_pkg::PADDR_W-1:0]        paddr,
    input  logic [stac_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [stac_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [stac_pkg::LIMIT_W-1:0]        o_limit
);
    import stac_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               wr_en;
    logic               hit;

    assign hit    = (paddr[PADDR_W-1] == REG_DEGEN_LIMIT);
    assign wr_en  = psel && penable && pwrite && hit;
    assign pready = 1'b1;
    assign o_limit = r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_W'(1);
        end else if (wr_en) begin
            r_limit <= pwdata[LIMIT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata = APB_DATA_W'(r_limit);
        end
    end

`ifndef NO_ASSERTIONS
    a_limit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_limit == $past(pwdata[LIMIT_W-1:0]))
        else $error("limit register did not take written value");
`endif

endmodule

### rtl/stac_front.sv
`timescale 1ns / 1ps
module stac_front (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  logic signed [stac_pkg::COORD_BITS-1:0]   i_a [3],
    input  logic signed [stac_pkg::COORD_BITS-1:0]   i_b [3],
    input  logic signed [stac_pkg::COORD_BITS-1:0]   i_c [3],
    input  logic signed [stac_pkg::COORD_BITS-1:0]   i_n [3],
    input  logic [stac_pkg::LIMIT_W-1:0]             i_limit,
    output logic                                     o_valid,
    output logic [stac_pkg::RAD_W-1:0]               o_rad,
    output stac_pkg::t_side                          o_side
);
    import stac_pkg::*;

    localparam int STAGES = 8;

    logic [STAGES-1:0]            r_valid;
    logic signed [DIFF_W-1:0]     r1_ab [3];
    logic signed [DIFF_W-1:0]     r1_bc [3];
    logic signed [COORD_BITS-1:0] r1_n [3];
    logic signed [COORD_BITS-1:0] r2_n [3];
    logic signed [COORD_BITS-1:0] r3_n [3];
    logic signed [PROD_W-1:0]     r2_p [6];
    logic signed [PROD_W-1:0]     r2_d [3];
    logic signed [CROSS_W-1:0]    r3_cr [3];
    logic signed [DOT_W-1:0]      r3_dot;
    logic [MAG_W-1:0]             n_mg [4];
    logic [MAG_W-1:0]             r4_mg [4];
    logic signed [NPROD_W-1:0]    r4_np [3];
    logic                         r4_dneg;
    logic [MAG_W-1:0]             r5_mg [4];
    logic [2*SMALL_BITS-1:0]      r5_sq [3];
    logic                         r5_small;
    logic                         r5_nneg;
    logic                         r5_dneg;
    logic [SHIFT_W-1:0]           r5_shift;
    logic [MAG_W-1:0]             n_or;
    logic [SHIFT_W-1:0]           n_shift;
    logic signed [NSUM_W-1:0]     n_nsum;
    logic                         n_small;
    logic [SCALE_BITS-1:0]        r6_m [3];
    t_side                        r6_side;
    logic [SQ_W-1:0]              r7_sq [3];
    t_side                        r7_side;
    logic [RAD_W-1:0]             r8_rad;
    t_side                        r8_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    // edges, products, cross and dot
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_ab[k] <= DIFF_W'(i_b[k]) - DIFF_W'(i_a[k]);
                r1_bc[k] <= DIFF_W'(i_c[k]) - DIFF_W'(i_b[k]);
                r1_n[k]  <= i_n[k];
                r2_n[k]  <= r1_n[k];
                r3_n[k]  <= r2_n[k];
                r2_d[k]  <= PROD_W'(r1_ab[k]) * PROD_W'(r1_bc[k]);
            end
            r2_p[0] <= PROD_W'(r1_ab[1]) * PROD_W'(r1_bc[2]);
            r2_p[1] <= PROD_W'(r1_ab[2]) * PROD_W'(r1_bc[1]);
            r2_p[2] <= PROD_W'(r1_ab[2]) * PROD_W'(r1_bc[0]);
            r2_p[3] <= PROD_W'(r1_ab[0]) * PROD_W'(r1_bc[2]);
            r2_p[4] <= PROD_W'(r1_ab[0]) * PROD_W'(r1_bc[1]);
            r2_p[5] <= PROD_W'(r1_ab[1]) * PROD_W'(r1_bc[0]);
            r3_cr[0] <= CROSS_W'(r2_p[0]) - CROSS_W'(r2_p[1]);
            r3_cr[1] <= CROSS_W'(r2_p[2]) - CROSS_W'(r2_p[3]);
            r3_cr[2] <= CROSS_W'(r2_p[4]) - CROSS_W'(r2_p[5]);
            r3_dot   <= DOT_W'(r2_d[0]) + DOT_W'(r2_d[1]) + DOT_W'(r2_d[2]);
        end
    end

    // magnitudes
    always_comb begin
        logic signed [MAG_W-1:0] e;
        for (int k = 0; k < 3; k++) begin
            e = MAG_W'(r3_cr[k]);
            n_mg[k] = (e < 0) ? MAG_W'(-e) : MAG_W'(e);
        end
        e = MAG_W'(r3_dot);
        n_mg[3] = (e < 0) ? MAG_W'(-e) : MAG_W'(e);
    end

    // small test, normal sign and scale shift
    always_comb begin
        n_small = 1'b1;
        n_or    = '0;
        n_shift = '0;
        for (int k = 0; k < 3; k++) begin
            if ((r4_mg[k] >> SMALL_BITS) != '0) n_small = 1'b0;
        end
        for (int k = 0; k < 4; k++) begin
            n_or = n_or | r4_mg[k];
        end
        for (int j = SCALE_BITS; j < MAG_W; j++) begin
            if (n_or[j]) n_shift = SHIFT_W'(j - SCALE_BITS + 1);
        end
        n_nsum = NSUM_W'(r4_np[0]) + NSUM_W'(r4_np[1]) + NSUM_W'(r4_np[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r4_mg[k] <= n_mg[k];
                r5_mg[k] <= r4_mg[k];
            end
            for (int k = 0; k < 3; k++) begin
                r4_np[k] <= NPROD_W'(r3_n[k]) * NPROD_W'(r3_cr[k]);
                r5_sq[k] <= r4_mg[k][SMALL_BITS-1:0] * r4_mg[k][SMALL_BITS-1:0];
                r6_m[k]  <= SCALE_BITS'(r5_mg[k] >> r5_shift);
                r7_sq[k] <= SQ_W'(r6_m[k]) * SQ_W'(r6_m[k]);
            end
            r4_dneg  <= r3_dot[DOT_W-1];
            r5_small <= n_small;
            r5_nneg  <= n_nsum[NSUM_W-1];
            r5_dneg  <= r4_dneg;
            r5_shift <= n_shift;
            r6_side.coll  <= r5_small &&
                (SQS_W'(r5_sq[0]) + SQS_W'(r5_sq[1]) + SQS_W'(r5_sq[2]) < SQS_W'(i_limit));
            r6_side.nneg  <= r5_nneg;
            r6_side.dneg  <= r5_dneg;
            r6_side.x_mag <= SCALE_BITS'(r5_mg[3] >> r5_shift);
            r7_side <= r6_side;
            r8_rad  <= RAD_W'(r7_sq[0]) + RAD_W'(r7_sq[1]) + RAD_W'(r7_sq[2]);
            r8_side <= r7_side;
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_rad   = r8_rad;
    assign o_side  = r8_side;

endmodule

### rtl/stac_sqrt.sv
`timescale 1ns / 1ps
module stac_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [stac_pkg::RAD_W-1:0]     i_rad,
    input  stac_pkg::t_side                i_side,
    output logic                           o_valid,
    output logic [stac_pkg::ROOT_W-1:0]    o_root,
    output stac_pkg::t_side                o_side
);
    import stac_pkg::*;

    // one result bit per stage, radicand consumed two bits at a time
    logic [ROOT_W-1:0] r_valid;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [RAD_W-1:0]  r_rad  [ROOT_W];
    t_side             r_side [ROOT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[ROOT_W-2:0], i_valid};
        end
    end

    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0]  p_rad;
        t_side             p_side;
        logic [REM_W-1:0]  n_sh;
        logic [REM_W-1:0]  n_trial;
        logic              n_ge;

        if (i == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_rest
            assign p_rem  = r_rem[i-1];
            assign p_root = r_root[i-1];
            assign p_rad  = r_rad[i-1];
            assign p_side = r_side[i-1];
        end

        always_comb begin
            n_sh    = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
            n_trial = REM_W'({p_root, 2'b01});
            n_ge    = (n_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= n_ge ? (n_sh - n_trial) : n_sh;
                r_root[i] <= {p_root[ROOT_W-2:0], n_ge};
                r_rad[i]  <= p_rad << 2;
                r_side[i] <= p_side;
            end
        end
    end

    assign o_valid = r_valid[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

`ifndef NO_ASSERTIONS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_rem[ROOT_W-1] <= REM_W'({o_root, 1'b0}))
        else $error("square root remainder exceeds 2*root");
`endif

endmodule

### rtl/stac_cordic.sv
`timescale 1ns / 1ps
module stac_cordic #(
    parameter int ANGLE_FRAC_BITS = stac_pkg::ANGLE_FRAC_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [stac_pkg::ROOT_W-1:0]          i_root,
    input  stac_pkg::t_side                      i_side,
    output logic                                 o_valid,
    output logic signed [stac_pkg::ANGLE_W-1:0]  o_angle,
    output logic                                 o_status
);
    import stac_pkg::*;

    localparam int NST    = CORDIC_STEPS;
    localparam int RND_SH = INT_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [ZW-1:0] Z_PI   = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0] Z_HPI  = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(64'sd1 <<< (RND_SH - 1));

    logic [NST+1:0]       r_valid;
    logic signed [CW-1:0] r_x [NST+1];
    logic signed [CW-1:0] r_y [NST+1];
    logic signed [ZW-1:0] r_z [NST+1];
    t_side                r_side [NST+1];
    logic                 r_yz [NST+1];
    logic                 r_ypi [NST+1];
    logic signed [ANGLE_W-1:0] r_angle;
    logic                 r_status;

    logic signed [CW-1:0] n_x0;
    logic signed [CW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;
    logic                 n_xneg;
    logic signed [ZW-1:0] n_zc;
    logic signed [ZW-1:0] n_zr;
    logic signed [ANGLE_W-1:0] n_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NST:0], i_valid};
        end
    end

    // left half plane: rotate by -90 degrees first, starting z at +90 degrees
    always_comb begin
        n_xneg = i_side.dneg && (i_side.x_mag != '0);
        if (n_xneg) begin
            n_x0 = CW'(i_root);
            n_y0 = CW'(i_side.x_mag);
            n_z0 = Z_HPI;
        end else begin
            n_x0 = CW'(i_side.x_mag);
            n_y0 = CW'(i_root);
            n_z0 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= n_x0;
            r_y[0]    <= n_y0;
            r_z[0]    <= n_z0;
            r_side[0] <= i_side;
            r_yz[0]   <= (i_root == '0);
            r_ypi[0]  <= n_xneg;
        end
    end

    for (genvar i = 0; i < NST; i++) begin : g_iter
        localparam logic signed [ZW-1:0] ANG = atan_q30(i);
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ANG;
                end
                r_side[i+1] <= r_side[i];
                r_yz[i+1]   <= r_yz[i];
                r_ypi[i+1]  <= r_ypi[i];
            end
        end
    end

    // clamp to [0, pi], round, apply normal sign, force collinear results to zero
    always_comb begin
        priority if (r_yz[NST]) begin
            n_zc = r_ypi[NST] ? Z_PI : '0;
        end else if (r_z[NST] < 0) begin
            n_zc = '0;
        end else if (r_z[NST] > Z_PI) begin
            n_zc = Z_PI;
        end else begin
            n_zc = r_z[NST];
        end
        n_zr    = (n_zc + Z_HALF) >>> RND_SH;
        n_angle = ANGLE_W'(n_zr);
        if (r_side[NST].nneg) n_angle = -n_angle;
        if (r_side[NST].coll) n_angle = '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle  <= n_angle;
            r_status <= r_side[NST].coll;
        end
    end

    assign o_valid  = r_valid[NST+1];
    assign o_angle  = r_angle;
    assign o_status = r_status;

`ifndef NO_ASSERTIONS
    a_prerot_y_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] && !r_yz[0] |-> r_y[0] > 0)
        else $error("CORDIC start vector not in upper half plane");
    a_coll_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_angle == '0)
        else $error("collinear result carries nonzero angle");
`endif

endmodule
